// ----- rtl/height_to_normal_map_assert.svh -----
// ----------------------------------------------------------------------------
// height_to_normal_map_assert.svh
// Assertion macros for the height-to-normal-map RTL.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define HNM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define HNM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hnm_pkg.sv -----
// ----------------------------------------------------------------------------
// hnm_pkg
// Types, constants and pipeline latencies of the height-to-normal-map block.
// ----------------------------------------------------------------------------
package hnm_pkg;

    // Height sample width default
    localparam int VALUE_BITS_DEF = 8;

    // Gain register: signed Q8.8, reset 1.0
    localparam int                  GAIN_BITS  = 16;
    localparam logic signed [15:0] GAIN_RESET = 16'sd256;

    // Constant z component of the gradient, Q.8, and its square
    localparam int          GZ_Q8 = 3072;
    localparam logic [31:0] GZ_SQ = 32'(GZ_Q8 * GZ_Q8);

    // Width of the gradient quotient before saturation
    localparam int GRAD_QBITS = 18;

    // Register map
    localparam int ADDR_BITS = 3;
    typedef enum logic {
        REG_HEIGHT_GAIN = 1'b0,
        REG_UNUSED      = 1'b1
    } reg_index_t;

    // Neighbor offsets, order nw, n, ne, w, e, sw, s, se (y positive upward)
    localparam int NUM_NB = 8;
    localparam int OFF_X [NUM_NB] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    localparam int OFF_Y [NUM_NB] = '{1, 1, 1, 0, 0, -1, -1, -1};

    // Stage counts of each unit
    localparam int MERGE_LAT = 1;
    localparam int GRAD_LAT  = 6;
    localparam int NORM_LAT  = 18;
    localparam int BYTE_LAT  = 10;
    localparam int PIPE_LAT  = MERGE_LAT + GRAD_LAT + NORM_LAT + BYTE_LAT;

    // One window around a pixel
    typedef struct packed {
        logic [7:0] center_value;
        logic [7:0] value_nw;
        logic [7:0] value_n;
        logic [7:0] value_ne;
        logic [7:0] value_w;
        logic [7:0] value_e;
        logic [7:0] value_sw;
        logic [7:0] value_s;
        logic [7:0] value_se;
        logic [7:0] neighbor_inside;
    } pixel_item_t;

    // Normal coded as three bytes
    typedef struct packed {
        logic [7:0] normal_red;
        logic [7:0] normal_green;
        logic [7:0] normal_blue;
    } normal_item_t;

endpackage

// ----- rtl/hnm_lane.sv -----
// ----------------------------------------------------------------------------
// hnm_lane
// One neighbor of the window: height difference against the center and its
// weighted x and y gradient terms.
// ----------------------------------------------------------------------------
module hnm_lane #(
    parameter int VALUE_BITS = hnm_pkg::VALUE_BITS_DEF,
    parameter int DX         = 0,
    parameter int DY         = 0
) (
    input  logic [VALUE_BITS-1:0]    center,
    input  logic [VALUE_BITS-1:0]    value,
    input  logic                     in_image,
    output logic signed [VALUE_BITS:0] a_term,
    output logic signed [VALUE_BITS:0] b_term
);

    logic signed [VALUE_BITS:0] diff;

    // An outside neighbor takes the center value, so it adds nothing
    assign diff = in_image ? ($signed({1'b0, value}) - $signed({1'b0, center}))
                           : '0;

    // Terms are -dx*d and -dy*d
    always_comb
    begin
        if (DX > 0)
            a_term = -diff;
        else if (DX < 0)
            a_term = diff;
        else
            a_term = '0;

        if (DY > 0)
            b_term = -diff;
        else if (DY < 0)
            b_term = diff;
        else
            b_term = '0;
    end

endmodule

// ----- rtl/hnm_grad.sv -----
// ----------------------------------------------------------------------------
// hnm_grad
// Gradient component: sum times gain, rounded divide by the largest height
// value (shift-sum estimate plus a small correction), saturated to 16 bits.
// ----------------------------------------------------------------------------
module hnm_grad #(
    parameter int VALUE_BITS = hnm_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [VALUE_BITS+3:0]  sum,
    input  logic signed [15:0]            gain,
    output logic signed [15:0]            grad
);

    localparam int SW   = VALUE_BITS + 4;
    localparam int PW   = SW + hnm_pkg::GAIN_BITS;
    localparam int QB   = hnm_pkg::GRAD_QBITS;
    localparam int MW   = VALUE_BITS + QB;
    localparam int RW   = VALUE_BITS + 4;
    localparam int NT   = (MW - 1) / VALUE_BITS;
    localparam int NC   = NT + 2;
    localparam int FW   = $clog2(NC + 1);
    localparam int VMAX = (1 << VALUE_BITS) - 1;
    localparam logic [MW-1:0] HALF = MW'(VMAX / 2);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [PW-1:0]        abs_val;
    logic [MW-1:0]        mag_reg;
    logic [MW-1:0]        mag_next;
    logic                 neg_reg;

    logic [QB-1:0] est_next;
    logic [QB-1:0] est_reg;
    logic [MW-1:0] num_reg;
    logic          neg_est_reg;

    logic [MW-1:0] rem_full;
    logic [RW-1:0] rem_reg;
    logic [QB-1:0] est_dly_reg;
    logic          neg_rem_reg;

    logic [FW-1:0] fix;
    logic [QB-1:0] quot_next;
    logic [QB-1:0] quot_reg;
    logic          quot_neg_reg;

    logic signed [15:0] grad_next;
    logic signed [15:0] grad_reg;

    // Product of gradient sum and gain
    assign prod_next = sum * gain;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    // Magnitude plus half the divisor for round half away from zero
    assign abs_val  = prod_reg[PW-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign mag_next = MW'(abs_val) + HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= prod_reg[PW-1];
        end
    end

    // Quotient estimate: m/(2^n-1) as the sum of m >> k*n, never too large
    always_comb
    begin
        est_next = '0;
        for (int k = 1; k <= NT; k++)
            est_next = est_next + QB'(mag_reg >> (k * VALUE_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est_reg     <= est_next;
            num_reg     <= mag_reg;
            neg_est_reg <= neg_reg;
        end
    end

    // Remainder left by the estimate, a few divisors at most
    assign rem_full = num_reg - {est_reg, VALUE_BITS'(0)} + MW'(est_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg     <= RW'(rem_full);
            est_dly_reg <= est_reg;
            neg_rem_reg <= neg_est_reg;
        end
    end

    // Correction: count the whole divisors still in the remainder
    always_comb
    begin
        fix = '0;
        for (int j = 1; j <= NC; j++)
            if (rem_reg >= RW'(j * VMAX))
                fix = fix + 1'b1;
    end

    assign quot_next = est_dly_reg + QB'(fix);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg     <= quot_next;
            quot_neg_reg <= neg_rem_reg;
        end
    end

    // Sign and saturation
    always_comb
    begin
        if (quot_neg_reg)
            grad_next = (quot_reg > QB'(32768)) ? 16'sh8000
                                                : $signed(16'(~quot_reg + 1'b1));
        else
            grad_next = (quot_reg > QB'(32767)) ? 16'sh7fff : $signed(quot_reg[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            grad_reg <= grad_next;
    end

    assign grad = grad_reg;

endmodule

// ----- rtl/hnm_norm.sv -----
// ----------------------------------------------------------------------------
// hnm_norm
// Length of the normal: squares of the gradient, sum with the fixed z term
// and a 16-stage integer square root. Gradients are delayed alongside.
// ----------------------------------------------------------------------------
module hnm_norm (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] gx,
    input  logic signed [15:0] gy,
    output logic [15:0]        len,
    output logic signed [15:0] gx_out,
    output logic signed [15:0] gy_out
);

    localparam int STEPS = 16;
    localparam int DLY   = hnm_pkg::NORM_LAT;

    logic signed [31:0] gx_sq_next;
    logic signed [31:0] gy_sq_next;
    logic [31:0]        gx_sq_reg;
    logic [31:0]        gy_sq_reg;
    logic [31:0]        sum_reg;

    logic [31:0] x_reg [STEPS];
    logic [31:0] r_reg [STEPS];

    logic signed [15:0] gx_dly [DLY];
    logic signed [15:0] gy_dly [DLY];

    // Squares, then the sum of squares
    assign gx_sq_next = gx * gx;
    assign gy_sq_next = gy * gy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_sq_reg <= $unsigned(gx_sq_next);
            gy_sq_reg <= $unsigned(gy_sq_next);
            sum_reg   <= gx_sq_reg + gy_sq_reg + hnm_pkg::GZ_SQ;
        end
    end

    // Digit-by-digit square root, two radicand bits per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_sqrt
        localparam logic [31:0] BIT = 32'(1) << (30 - 2 * k);
        logic [31:0] x_in;
        logic [31:0] r_in;
        logic [32:0] t;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign x_in = sum_reg;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign t  = {1'b0, r_in} + {1'b0, BIT};
        assign ge = {1'b0, x_in} >= t;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= ge ? 32'({1'b0, x_in} - t) : x_in;
                r_reg[k] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
            end
        end
    end

    // Gradient delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_dly[0] <= gx;
            gy_dly[0] <= gy;
            for (int i = 1; i < DLY; i++)
            begin
                gx_dly[i] <= gx_dly[i-1];
                gy_dly[i] <= gy_dly[i-1];
            end
        end
    end

    assign len    = r_reg[STEPS-1][15:0];
    assign gx_out = gx_dly[DLY-1];
    assign gy_out = gy_dly[DLY-1];

endmodule

// ----- rtl/hnm_byte.sv -----
// ----------------------------------------------------------------------------
// hnm_byte
// Maps one normal component c with length L to a byte:
// floor((255*(c+L) + L) / (2*L)), eight quotient bits, one per stage.
// ----------------------------------------------------------------------------
module hnm_byte (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] comp,
    input  logic [15:0]        len,
    output logic [7:0]         code
);

    localparam int STEPS = 8;
    localparam int DW    = 17;
    localparam int NW    = DW + STEPS;

    logic signed [17:0] shifted;
    logic [DW-1:0]      s_reg;
    logic [15:0]        len_reg;
    logic [NW-1:0]      n_reg;
    logic [DW-1:0]      d_reg;

    logic [DW-1:0]    rem_reg [STEPS];
    logic [STEPS-1:0] lq_reg  [STEPS];
    logic [DW-1:0]    div_reg [STEPS];

    // c + L, never negative since |c| <= L
    assign shifted = $signed({2'b00, len}) + 18'(comp);

    // Numerator and divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= shifted[DW-1:0];
            len_reg <= len;
            n_reg   <= {s_reg, 8'b0} - NW'(s_reg) + NW'(len_reg);
            d_reg   <= {len_reg, 1'b0};
        end
    end

    // Restoring division, quotient below 256
    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        logic [DW-1:0]    rem_in;
        logic [STEPS-1:0] lq_in;
        logic [DW-1:0]    div_in;
        logic [DW:0]      trial;
        logic [DW:0]      diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = n_reg[NW-1 -: DW];
            assign lq_in  = n_reg[STEPS-1:0];
            assign div_in = d_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign lq_in  = lq_reg[k-1];
            assign div_in = div_reg[k-1];
        end

        assign trial = {rem_in, lq_in[STEPS-1]};
        assign ge    = trial >= {1'b0, div_in};
        assign diff  = trial - {1'b0, div_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                lq_reg[k]  <= {lq_in[STEPS-2:0], ge};
                div_reg[k] <= div_in;
            end
        end
    end

    assign code = lq_reg[STEPS-1];

endmodule

// ----- rtl/height_to_normal_map.sv -----
// ----------------------------------------------------------------------------
// height_to_normal_map
// Top level: 3x3 height window to a normal map pixel, APB gain register.
// ----------------------------------------------------------------------------
// The block takes one window per clock while pixel_stall is low and returns
// one normal per window, in order. Each item passes through the merge register,
// the six-stage gradient scaler, the squares and sum registers, the 16-stage
// square root, the numerator registers and the 8-stage byte divider, all fully
// pipelined, and then reaches the output register.
// The whole pipeline holds while the output skid stage is full; a finished
// result waiting downstream does not stop the next item. The gain register
// is written over APB at address 0 and should be changed only while the
// block is empty. There is no start-up pass: items are taken right after
// reset.
module height_to_normal_map #(
    parameter int VALUE_BITS = hnm_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hnm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  hnm_pkg::pixel_item_t          pixel,

    output logic                          normal_valid,
    input  logic                          normal_stall,
    output hnm_pkg::normal_item_t         normal
);

`include "height_to_normal_map_assert.svh"

    localparam int NB  = hnm_pkg::NUM_NB;
    localparam int SW  = VALUE_BITS + 4;
    localparam int LAT = hnm_pkg::PIPE_LAT;

    // Configuration
    logic signed [15:0]  gain_reg;
    hnm_pkg::reg_index_t reg_sel;

    // Pipeline control
    logic           en;
    logic [LAT-1:0] valid_pipe_reg;

    // Lanes and merge
    logic [VALUE_BITS-1:0]     center;
    logic [VALUE_BITS-1:0]     nb_val  [NB];
    logic signed [VALUE_BITS:0] a_term [NB];
    logic signed [VALUE_BITS:0] b_term [NB];
    logic signed [SW-1:0]      a_next;
    logic signed [SW-1:0]      b_next;
    logic signed [SW-1:0]      a_reg;
    logic signed [SW-1:0]      b_reg;

    // Later stages
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [15:0]        len;
    logic signed [15:0] gx_d;
    logic signed [15:0] gy_d;
    hnm_pkg::normal_item_t res;

    // Output register and skid
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    hnm_pkg::normal_item_t out_reg;
    hnm_pkg::normal_item_t skid_reg;

    // ---------------- APB register ----------------
    assign pready  = 1'b1;
    assign reg_sel = hnm_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= hnm_pkg::GAIN_RESET;
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                hnm_pkg::REG_HEIGHT_GAIN: gain_reg <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hnm_pkg::REG_HEIGHT_GAIN: prdata = {{16{gain_reg[15]}}, gain_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign en          = !skid_valid_reg;
    assign pixel_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else if (en)
            valid_pipe_reg <= {valid_pipe_reg[LAT-2:0], pixel_valid};
    end

    // ---------------- neighbor lanes ----------------
    assign center    = VALUE_BITS'(pixel.center_value);
    assign nb_val[0] = VALUE_BITS'(pixel.value_nw);
    assign nb_val[1] = VALUE_BITS'(pixel.value_n);
    assign nb_val[2] = VALUE_BITS'(pixel.value_ne);
    assign nb_val[3] = VALUE_BITS'(pixel.value_w);
    assign nb_val[4] = VALUE_BITS'(pixel.value_e);
    assign nb_val[5] = VALUE_BITS'(pixel.value_sw);
    assign nb_val[6] = VALUE_BITS'(pixel.value_s);
    assign nb_val[7] = VALUE_BITS'(pixel.value_se);

    for (genvar i = 0; i < NB; i++)
    begin : g_lane
        hnm_lane #(
            .VALUE_BITS (VALUE_BITS),
            .DX         (hnm_pkg::OFF_X[i]),
            .DY         (hnm_pkg::OFF_Y[i])
        ) u_lane (
            .center   (center),
            .value    (nb_val[i]),
            .in_image (pixel.neighbor_inside[i]),
            .a_term   (a_term[i]),
            .b_term   (b_term[i])
        );
    end

    // Merge: gradient sums over the eight lanes
    always_comb
    begin
        a_next = '0;
        b_next = '0;
        for (int i = 0; i < NB; i++)
        begin
            a_next = a_next + SW'(a_term[i]);
            b_next = b_next + SW'(b_term[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // ---------------- gradient, length, bytes ----------------
    hnm_grad #(.VALUE_BITS(VALUE_BITS)) u_grad_x (
        .clk  (clk),
        .en   (en),
        .sum  (a_reg),
        .gain (gain_reg),
        .grad (gx)
    );

    hnm_grad #(.VALUE_BITS(VALUE_BITS)) u_grad_y (
        .clk  (clk),
        .en   (en),
        .sum  (b_reg),
        .gain (gain_reg),
        .grad (gy)
    );

    hnm_norm u_norm (
        .clk    (clk),
        .en     (en),
        .gx     (gx),
        .gy     (gy),
        .len    (len),
        .gx_out (gx_d),
        .gy_out (gy_d)
    );

    hnm_byte u_byte_r (
        .clk  (clk),
        .en   (en),
        .comp (gx_d),
        .len  (len),
        .code (res.normal_red)
    );

    hnm_byte u_byte_g (
        .clk  (clk),
        .en   (en),
        .comp (gy_d),
        .len  (len),
        .code (res.normal_green)
    );

    hnm_byte u_byte_b (
        .clk  (clk),
        .en   (en),
        .comp (16'(hnm_pkg::GZ_Q8)),
        .len  (len),
        .code (res.normal_blue)
    );

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (valid_pipe_reg[LAT-1])
            begin
                if (out_valid_reg && normal_stall)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (!normal_stall)
                out_valid_reg <= 1'b0;
        end
        else if (!normal_stall)
            skid_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (valid_pipe_reg[LAT-1])
            begin
                if (out_valid_reg && normal_stall)
                    skid_reg <= res;
                else
                    out_reg <= res;
            end
        end
        else if (!normal_stall)
            out_reg <= skid_reg;
    end

    assign normal_valid = out_valid_reg;
    assign normal       = out_reg;

    // ---------------- assertions ----------------
    `HNM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, normal_valid,
        "skid holds an item while the output register is empty")
    `HNM_ASSERT_IMP(a_skid_fill, $rose(skid_valid_reg), $past(normal_valid && normal_stall),
        "skid filled without a held output")
    `HNM_ASSERT_NXT(a_pipe_hold, pixel_stall, $stable(valid_pipe_reg),
        "pipeline moved while stalled")

endmodule

// ----- verif/tb_height_to_normal_map.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_height_to_normal_map
// Self-checking bench for the height window to normal map block.
// Feeds 3x3 height windows with neighbor masks through the valid/stall port.
// Each accepted window is turned into an expected normal by an independent
// fixed-point model, and every normal that comes out is compared field by
// field. The gain register is swept over APB between phases, including both
// extremes; in most phases both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_height_to_normal_map;

    localparam int VALUE_BITS  = 8;
    localparam int VMAX        = (1 << VALUE_BITS) - 1;
    localparam int GZ          = 12 * 256;
    localparam int CYCLE_LIMIT = 100000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 88;
    localparam int HOLD_CYCLES = 400;

    // Expected normals, computed as windows are accepted
    class normal_scoreboard;
        logic signed [15:0]    height_gain;
        hnm_pkg::normal_item_t expected_normals [$];
        int                    windows_seen;
        int                    normals_checked;
        int                    errors;

        function new();
            height_gain     = 16'sd256;
            windows_seen    = 0;
            normals_checked = 0;
            errors          = 0;
        endfunction

        // Height difference of one neighbor; outside neighbors read as center
        function int rise(bit in_image, logic [7:0] v, int c);
            return in_image ? int'(v) - c : 0;
        endfunction

        // Gradient sum times gain over VMAX, rounded half away from zero, Q.8
        function int scale_gradient(int s);
            longint p;
            longint mag;
            longint q;
            p   = longint'(s) * longint'(height_gain);
            mag = (p < 0) ? -p : p;
            q   = (mag + VMAX / 2) / VMAX;
            if (p >= 0)
                return (q > 32767) ? 32767 : int'(q);
            return (q > 32768) ? -32768 : -int'(q);
        endfunction

        // Largest r with r*r <= x
        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        // Map component in [-len, len] to a byte, rounded
        function logic [7:0] code_component(int comp, longint len);
            longint num;
            num = 510 * (longint'(comp) + len) + 2 * len;
            return 8'(num / (4 * len));
        endfunction

        function hnm_pkg::normal_item_t compute_normal(hnm_pkg::pixel_item_t w);
            int c;
            int d_nw, d_n, d_ne, d_w, d_e, d_sw, d_s, d_se;
            int sum_x, sum_y, gx, gy;
            longint len;
            hnm_pkg::normal_item_t n;
            c    = w.center_value;
            d_nw = rise(w.neighbor_inside[0], w.value_nw, c);
            d_n  = rise(w.neighbor_inside[1], w.value_n,  c);
            d_ne = rise(w.neighbor_inside[2], w.value_ne, c);
            d_w  = rise(w.neighbor_inside[3], w.value_w,  c);
            d_e  = rise(w.neighbor_inside[4], w.value_e,  c);
            d_sw = rise(w.neighbor_inside[5], w.value_sw, c);
            d_s  = rise(w.neighbor_inside[6], w.value_s,  c);
            d_se = rise(w.neighbor_inside[7], w.value_se, c);
            // x: -dx*d, y: -dy*d with y pointing up
            sum_x = d_nw - d_ne + d_w - d_e + d_sw - d_se;
            sum_y = -d_nw - d_n - d_ne + d_sw + d_s + d_se;
            gx    = scale_gradient(sum_x);
            gy    = scale_gradient(sum_y);
            len   = longint'(root_floor(longint'(gx) * gx + longint'(gy) * gy
                                        + longint'(GZ) * GZ));
            n.normal_red   = code_component(gx, len);
            n.normal_green = code_component(gy, len);
            n.normal_blue  = code_component(GZ, len);
            return n;
        endfunction

        function void note_window(hnm_pkg::pixel_item_t w);
            expected_normals.insert(expected_normals.size(), compute_normal(w));
            windows_seen++;
        endfunction

        function void check_normal(hnm_pkg::normal_item_t got);
            hnm_pkg::normal_item_t want;
            if (expected_normals.size() == 0)
            begin
                $display("%0t: normal with none expected: %h", $time, got);
                errors++;
                return;
            end
            want = expected_normals.pop_front();
            normals_checked++;
            if (got.normal_red !== want.normal_red)
            begin
                $display("%0t: normal_red expected %0d actual %0d",
                         $time, want.normal_red, got.normal_red);
                errors++;
            end
            if (got.normal_green !== want.normal_green)
            begin
                $display("%0t: normal_green expected %0d actual %0d",
                         $time, want.normal_green, got.normal_green);
                errors++;
            end
            if (got.normal_blue !== want.normal_blue)
            begin
                $display("%0t: normal_blue expected %0d actual %0d",
                         $time, want.normal_blue, got.normal_blue);
                errors++;
            end
        endfunction

        function int pending();
            return expected_normals.size();
        endfunction
    endclass

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [hnm_pkg::ADDR_BITS-1:0] paddr        = '0;
    logic [31:0]                   pwdata       = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          pixel_valid  = 1'b0;
    logic                          pixel_stall;
    hnm_pkg::pixel_item_t          pixel        = '0;
    logic                          normal_valid;
    logic                          normal_stall = 1'b0;
    hnm_pkg::normal_item_t         normal;

    normal_scoreboard     sb;
    int                   cycle_count  = 0;
    int                   hold_until   = 0;
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    int                   gain_writes  = 0;

    height_to_normal_map #(
        .VALUE_BITS   (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .normal_valid (normal_valid),
        .normal_stall (normal_stall),
        .normal       (normal)
    );

    always #4 clk = ~clk;

    // Cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached, %0d normals outstanding",
                     $time, sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: check accepted normals, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && normal_valid && !normal_stall)
            sb.check_normal(normal);
        normal_stall <= (cycle_count < hold_until) ||
                        ($urandom_range(0, 99) < rx_stall_pct);
    end

    // APB write: setup phase, access phase, then idle
    task automatic write_register(hnm_pkg::reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hnm_pkg::REG_HEIGHT_GAIN)
        begin
            sb.height_gain = value[15:0];
            gain_writes++;
        end
        @(posedge clk);
    endtask

    // APB read of the gain, compared with the bench copy
    task automatic check_gain_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {hnm_pkg::REG_HEIGHT_GAIN, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[15:0] !== sb.height_gain)
        begin
            $display("%0t: height_gain read expected %h actual %h",
                     $time, sb.height_gain, prdata[15:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_gain(logic signed [15:0] g);
        write_register(hnm_pkg::REG_HEIGHT_GAIN, {{16{g[15]}}, g});
        check_gain_readback();
    endtask

    // Offer one window, idling at random first; returns on acceptance
    task automatic send_window(hnm_pkg::pixel_item_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel       <= w;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        sb.note_window(w);
    endtask

    // Stop sending and wait until every expected normal has come back
    task automatic drain();
        pixel_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Byte near c, within +-8, clamped
    function automatic logic [7:0] near(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Mix of uniform, smooth terrain, hard edges of lowest and highest height, and flat windows
    function automatic hnm_pkg::pixel_item_t random_window();
        hnm_pkg::pixel_item_t w;
        int kind;
        kind = $urandom_range(0, 9);
        w    = hnm_pkg::pixel_item_t'(80'({$urandom(), $urandom(), $urandom()}));
        if (kind >= 4 && kind <= 6)
        begin
            w.value_nw = near(w.center_value);
            w.value_n  = near(w.center_value);
            w.value_ne = near(w.center_value);
            w.value_w  = near(w.center_value);
            w.value_e  = near(w.center_value);
            w.value_sw = near(w.center_value);
            w.value_s  = near(w.center_value);
            w.value_se = near(w.center_value);
            if ($urandom_range(0, 3) != 0)
                w.neighbor_inside = 8'hff;
        end
        else if (kind >= 7 && kind <= 8)
        begin
            w.center_value = {8{$urandom_range(0, 1) == 1}};
            w.value_nw     = {8{$urandom_range(0, 1) == 1}};
            w.value_n      = {8{$urandom_range(0, 1) == 1}};
            w.value_ne     = {8{$urandom_range(0, 1) == 1}};
            w.value_w      = {8{$urandom_range(0, 1) == 1}};
            w.value_e      = {8{$urandom_range(0, 1) == 1}};
            w.value_sw     = {8{$urandom_range(0, 1) == 1}};
            w.value_s      = {8{$urandom_range(0, 1) == 1}};
            w.value_se     = {8{$urandom_range(0, 1) == 1}};
        end
        else if (kind == 9)
        begin
            w.value_nw = w.center_value;
            w.value_n  = w.center_value;
            w.value_ne = w.center_value;
            w.value_w  = w.center_value;
            w.value_e  = w.center_value;
            w.value_sw = w.center_value;
            w.value_s  = w.center_value;
            w.value_se = w.center_value;
        end
        return w;
    endfunction

    // Corner cases at the reset gain
    task automatic send_directed();
        // flat extremes, full mask
        send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                           8'd0, 8'd0, 8'hff});
        send_window(hnm_pkg::pixel_item_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                           8'd255, 8'd255, 8'd255, 8'd255, 8'hff});
        // pit and peak
        send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                                           8'd255, 8'd255, 8'd255, 8'd255, 8'hff});
        send_window(hnm_pkg::pixel_item_t'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                           8'd0, 8'd0, 8'hff});
        // all neighbors outside: flat whatever the values
        send_window(hnm_pkg::pixel_item_t'{8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                           8'd255, 8'd0, 8'd255, 8'h00});
        // steepest ramps in x and y, both signs
        send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0,
                                           8'd255, 8'd0, 8'd0, 8'hff});
        send_window(hnm_pkg::pixel_item_t'{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
                                           8'd0, 8'd255, 8'd255, 8'hff});
        send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
                                           8'd0, 8'd0, 8'd0, 8'hff});
        send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                           8'd255, 8'd255, 8'd255, 8'hff});
        // diagonal step
        send_window(hnm_pkg::pixel_item_t'{8'd128, 8'd255, 8'd128, 8'd128, 8'd128,
                                           8'd128, 8'd128, 8'd128, 8'd0, 8'hff});
        // one neighbor inside at a time
        for (int k = 0; k < 8; k++)
            send_window(hnm_pkg::pixel_item_t'{8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                                               8'd255, 8'd255, 8'd255, 8'd255,
                                               8'(1 << k)});
        // alternating masks with random heights
        send_window(hnm_pkg::pixel_item_t'({8'($urandom()), 32'($urandom()),
                                            32'($urandom()), 8'h55}));
        send_window(hnm_pkg::pixel_item_t'({8'($urandom()), 32'($urandom()),
                                            32'($urandom()), 8'haa}));
    endtask

    // Stimulus
    initial
    begin
        logic signed [15:0] gain_plan [NUM_PHASES];
        sb = new();
        gain_plan = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd0,
                      16'sd256, 16'sd0};
        gain_plan[5] = 16'($urandom());
        gain_plan[7] = 16'($signed($urandom_range(0, 2048)) - 1024);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed windows at the reset gain, reset value read back first
        check_gain_readback();
        tx_idle_pct  = 32;
        rx_stall_pct = 48;
        send_directed();
        drain();

        // Random phases, one gain setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct  = 32;
                rx_stall_pct = 48;
            end
            else if (p < 6)
            begin
                tx_idle_pct  = 48;
                rx_stall_pct = 32;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            write_gain(gain_plan[p]);
            // write to the unused register must leave the gain alone
            if (p == 4)
            begin
                write_register(hnm_pkg::REG_UNUSED, $urandom());
                check_gain_readback();
            end
            // long receiver hold so the pipeline fills and stalls the input
            if (p == 2)
                hold_until = cycle_count + HOLD_CYCLES;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_window(random_window());
            drain();
        end

        // Watch for stray normals after the last one
        repeat (2 * hnm_pkg::PIPE_LAT) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected normals never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Sent %0d windows over %0d gain writes, with idle gaps, stalls and a",
                 sb.windows_seen, gain_writes);
        $display("%0d-cycle output hold; %0d normals checked, %0d mismatches",
                 HOLD_CYCLES, sb.normals_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hnm_pkg.sv
rtl/hnm_lane.sv
rtl/hnm_grad.sv
rtl/hnm_norm.sv
rtl/hnm_byte.sv
rtl/height_to_normal_map.sv
verif/tb_height_to_normal_map.sv
